// File: rtl/julian_day_to_calendar_date_assert.svh
// assertion macros for the julian day to calendar date block
// expects signals named clk and rst in the including module
`ifndef JULIAN_DAY_TO_CALENDAR_DATE_ASSERT_SVH
`define JULIAN_DAY_TO_CALENDAR_DATE_ASSERT_SVH

// same-cycle implication
`define JDC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jdc assertion failed");

// next-cycle implication
`define JDC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jdc assertion failed");

`endif

// File: rtl/jdc_pkg.sv
// shared types and constants for the julian day to calendar date block
// no dependencies
package jdc_pkg;

  typedef logic [30:0]        julian_day_t;
  typedef logic [4:0]         day_t;
  typedef logic [3:0]         month_t;
  typedef logic signed [23:0] year_t;

  localparam int unsigned GREG_START     = 2299161;
  localparam int unsigned GREG_OFFSET    = 68569;
  localparam int unsigned GREG_CYCLE     = 146097;
  localparam int unsigned GREG_YEAR_DIV  = 1461001;
  localparam int unsigned YEAR_SCALE     = 4000;
  localparam int unsigned LEAP_CYCLE     = 1461;
  localparam int unsigned MONTH_DIV      = 2447;
  localparam int unsigned MONTH_SCALE    = 80;
  localparam int unsigned MARCH_OFFSET   = 31;
  localparam int unsigned CENTURY_BIAS   = 49;
  localparam int unsigned CENTURY_YEARS  = 100;
  localparam int unsigned JUL_OFFSET     = 32082;
  localparam int unsigned JUL_MONTH_DIV  = 153;
  localparam int unsigned EPOCH_YEAR     = 4800;

  // exact divide by five for operands below 1024
  localparam int unsigned FIFTH_MUL      = 205;
  localparam int unsigned FIFTH_SHIFT    = 10;

  // divider operand widths
  localparam int X1W = 34;
  localparam int X2W = 28;
  localparam int X3W = 17;
  localparam int X4W = 24;
  localparam int X5W = 11;

  localparam int LAST_STAGE = 12;

endpackage

// File: rtl/jdc_if.sv
// valid/ready channel interfaces for the julian day to calendar date block
// depends on jdc_pkg
interface jdc_day_if;
  import jdc_pkg::*;

  logic        valid;
  logic        ready;
  julian_day_t julian_day;

  modport source (output valid, output julian_day, input ready);
  modport sink (input valid, input julian_day, output ready);
endinterface

interface jdc_date_if;
  import jdc_pkg::*;

  logic   valid;
  logic   ready;
  day_t   day_of_month;
  month_t month_number;
  year_t  year_number;

  modport source (output valid, output day_of_month, output month_number,
                  output year_number, input ready);
  modport sink (input valid, input day_of_month, input month_number,
                input year_number, output ready);
endinterface

// File: rtl/jdc_cdiv.sv
// three-stage divider by a constant: reciprocal estimate, back-multiply, one correction
// no dependencies
module jdc_cdiv #(
  parameter int          XW = 16,
  parameter int unsigned D  = 3
) (
  input  logic          clk,
  input  logic          en,
  input  logic [XW-1:0] x,
  output logic [XW-1:0] q,
  output logic [XW-1:0] r
);

  localparam int MW = XW - $clog2(D) + 1;
  localparam int PW = XW + MW;
  localparam logic [MW-1:0] RECIP   = MW'((64'd1 << XW) / 64'(D));
  localparam logic [XW-1:0] DIVISOR = XW'(D);

  logic [XW-1:0] x_s1;
  logic [PW-1:0] prod;
  logic [XW-1:0] x_s2;
  logic [MW-1:0] est;
  logic [XW-1:0] back;
  logic [MW-1:0] est_c;
  logic [XW-1:0] diff;
  logic          over;

  assign est_c = prod[PW-1:XW];
  assign diff  = x_s2 - back;
  assign over  = diff >= DIVISOR;

  always_ff @(posedge clk) begin
    if (en) begin
      x_s1 <= x;
      prod <= PW'(x) * PW'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_s2 <= x_s1;
      est  <= est_c;
      back <= XW'(est_c) * DIVISOR;
    end
  end

  // estimate is at most one short
  always_ff @(posedge clk) begin
    if (en) begin
      q <= over ? XW'(est) + XW'(1) : XW'(est);
      r <= over ? diff - DIVISOR : diff;
    end
  end

endmodule

// File: rtl/julian_day_to_calendar_date.sv
// julian day number to calendar date, top level
// depends on jdc_pkg, jdc_if, jdc_cdiv and julian_day_to_calendar_date_assert.svh
//
// days: input channel, one julian day number per word (31 bits, unsigned).
// date: output channel, one word per input word with day, month and year;
//   days from 2299161 on follow the gregorian calendar, earlier days the
//   julian calendar, with no year zero (negative years are bc).
// a word is taken when valid and ready are high at a rising edge of clk.
// throughput: one word per cycle while date is not stalled, set by a 13-stage pipeline with
//   five three-stage constant dividers; no state is kept between words.
// when date is stalled with a word waiting, the whole pipeline holds and
//   days.ready drops; nothing is lost or repeated. while the last stage is
//   empty the pipeline keeps moving even with date.ready low.
// rst (synchronous, active high) empties the pipeline and holds days.ready
//   low; the block takes words in the cycle after rst is released.
`include "julian_day_to_calendar_date_assert.svh"

module julian_day_to_calendar_date (
  input logic         clk,
  input logic         rst,
  jdc_day_if.sink     days,
  jdc_date_if.source  date
);
  import jdc_pkg::*;

  logic                  adv;
  logic [LAST_STAGE:0]   vld;
  logic [LAST_STAGE:0]   greg;

  logic [X1W-1:0]        x1;
  logic [X4W-1:0]        x4;
  logic [X1W-1:0]        n_q;
  logic [X1W-1:0]        n_r;
  logic [X4W-1:0]        dd_q;
  logic [X4W-1:0]        dd_r;

  logic [X2W-1:0]        x2;
  logic [X5W-1:0]        x5;
  logic [15:0]           l1_c;
  logic [15:0]           n_p [4:7];
  logic [15:0]           l1_p [4:7];
  logic [12:0]           dd_p [4:7];
  logic [X2W-1:0]        i_q;
  logic [X2W-1:0]        i_r;
  logic [X5W-1:0]        mm_q;
  logic [X5W-1:0]        mm_r;

  logic [17:0]           gl2_prod;
  logic [9:0]            gl2;
  logic [3:0]            mm;
  logic                  jlate;
  logic [15:0]           jday_prod;
  year_t                 jy_raw;
  logic [X3W-1:0]        x3;
  logic [23:0]           ybase_p [8:11];
  day_t                  jday_p [8:11];
  month_t                jmon_p [8:11];
  year_t                 jyear_p [8:11];
  logic [X3W-1:0]        j_q;
  logic [X3W-1:0]        j_r;

  logic [11:0]           g_r80;
  logic [15:0]           g_prod;
  logic [4:0]            gj;
  logic                  glate;
  day_t                  gday;
  month_t                gmon;
  year_t                 gyear;

  day_t                  day;
  month_t                month;
  year_t                 year;

  assign adv        = !vld[LAST_STAGE] || date.ready;
  assign days.ready = adv && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST_STAGE-1:0], days.valid};
    end
  end

  // stage 0: branch flag and divider operands
  always_ff @(posedge clk) begin
    if (adv) begin
      greg <= {greg[LAST_STAGE-1:0], days.julian_day >= 31'(GREG_START)};
      x1   <= {32'(days.julian_day) + 32'(GREG_OFFSET), 2'b00};
      x4   <= {22'(days.julian_day) + 22'(JUL_OFFSET), 2'b11};
    end
  end

  // stages 1 to 3
  jdc_cdiv #(.XW(X1W), .D(GREG_CYCLE)) u_div_cent (
    .clk (clk),
    .en  (adv),
    .x   (x1),
    .q   (n_q),
    .r   (n_r)
  );

  jdc_cdiv #(.XW(X4W), .D(LEAP_CYCLE)) u_div_jyear (
    .clk (clk),
    .en  (adv),
    .x   (x4),
    .q   (dd_q),
    .r   (dd_r)
  );

  // stage 4
  assign l1_c = n_r[17:2];

  always_ff @(posedge clk) begin
    if (adv) begin
      x2      <= X2W'(YEAR_SCALE) * X2W'(l1_c + 16'd1);
      x5      <= 11'd5 * 11'(dd_r[10:2]) + 11'd2;
      n_p[4]  <= n_q[15:0];
      l1_p[4] <= l1_c;
      dd_p[4] <= dd_q[12:0];
      for (int k = 5; k <= 7; k++) begin
        n_p[k]  <= n_p[k-1];
        l1_p[k] <= l1_p[k-1];
        dd_p[k] <= dd_p[k-1];
      end
    end
  end

  // stages 5 to 7
  jdc_cdiv #(.XW(X2W), .D(GREG_YEAR_DIV)) u_div_gyear (
    .clk (clk),
    .en  (adv),
    .x   (x2),
    .q   (i_q),
    .r   (i_r)
  );

  jdc_cdiv #(.XW(X5W), .D(JUL_MONTH_DIV)) u_div_jmonth (
    .clk (clk),
    .en  (adv),
    .x   (x5),
    .q   (mm_q),
    .r   (mm_r)
  );

  // stage 8: gregorian month operand, julian date finished
  always_comb begin
    gl2_prod  = 18'(LEAP_CYCLE) * 18'(i_q[6:0]);
    gl2       = 10'(l1_p[7] + 16'(MARCH_OFFSET) - 16'(gl2_prod[17:2]));
    mm        = mm_q[3:0];
    jlate     = mm >= 4'd10;
    jday_prod = 16'(mm_r[7:0]) * 16'(FIFTH_MUL);
    jy_raw    = $signed({11'd0, dd_p[7]}) - year_t'(EPOCH_YEAR)
                + (jlate ? year_t'(1) : year_t'(0));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x3         <= X3W'(gl2) * X3W'(MONTH_SCALE);
      ybase_p[8] <= (24'(n_p[7]) - 24'(CENTURY_BIAS)) * 24'(CENTURY_YEARS)
                    + 24'(i_q[6:0]);
      jday_p[8]  <= 5'd1 + 5'(jday_prod[15:FIFTH_SHIFT]);
      jmon_p[8]  <= jlate ? mm - 4'd9 : mm + 4'd3;
      // no year zero
      jyear_p[8] <= (jy_raw <= year_t'(0)) ? jy_raw - year_t'(1) : jy_raw;
      for (int k = 9; k <= 11; k++) begin
        ybase_p[k] <= ybase_p[k-1];
        jday_p[k]  <= jday_p[k-1];
        jmon_p[k]  <= jmon_p[k-1];
        jyear_p[k] <= jyear_p[k-1];
      end
    end
  end

  // stages 9 to 11
  jdc_cdiv #(.XW(X3W), .D(MONTH_DIV)) u_div_gmonth (
    .clk (clk),
    .en  (adv),
    .x   (x3),
    .q   (j_q),
    .r   (j_r)
  );

  // stage 12: gregorian date finished, branch select
  always_comb begin
    g_r80  = 12'(j_r[11:0]) + 12'd79;
    g_prod = 16'(g_r80[11:4]) * 16'(FIFTH_MUL);
    gday   = 5'(g_prod[15:FIFTH_SHIFT]);
    gj     = j_q[4:0];
    glate  = gj >= 5'd11;
    gmon   = glate ? 4'(gj - 5'd10) : 4'(gj + 5'd2);
    gyear  = year_t'(ybase_p[11] + (glate ? 24'd1 : 24'd0));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      day   <= greg[11] ? gday : jday_p[11];
      month <= greg[11] ? gmon : jmon_p[11];
      year  <= greg[11] ? gyear : jyear_p[11];
    end
  end

  assign date.valid        = vld[LAST_STAGE];
  assign date.day_of_month = day;
  assign date.month_number = month;
  assign date.year_number  = year;

  `JDC_ASSERT_IMP(a_month_range, vld[LAST_STAGE],
    date.month_number != 4'd0 && date.month_number <= 4'd12)
  `JDC_ASSERT_IMP(a_day_range, vld[LAST_STAGE], date.day_of_month != 5'd0)
  `JDC_ASSERT_IMP(a_greg_year, vld[LAST_STAGE] && greg[LAST_STAGE],
    date.year_number >= 24'sd1582)
  `JDC_ASSERT_IMP(a_jul_year, vld[LAST_STAGE] && !greg[LAST_STAGE],
    date.year_number != 24'sd0 && date.year_number >= -24'sd4713 && date.year_number <= 24'sd1582)
  `JDC_ASSERT_IMP(a_gyear_rem, vld[7], i_r < X2W'(GREG_YEAR_DIV))
  `JDC_ASSERT_NXT(a_stall_freeze, !adv, $stable(vld))

endmodule
